@@ src/htfr_pkg.sv @@
// Shared constants and types for the header/trailer frame receiver.
package htfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned BUF_DEPTH = 8;
  localparam int unsigned IDX_W     = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int unsigned CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned ADDR_W    = REG_IDX_W + 2;
  localparam int unsigned APB_W     = 32;

  localparam logic [BYTE_W-1:0] HEADER_RST   = 8'h33;
  localparam logic [BYTE_W-1:0] TRAILER1_RST = 8'h44;
  localparam logic [BYTE_W-1:0] TRAILER2_RST = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 4'd6;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEADER   = 2'd0,
    REG_TRAILER1 = 2'd1,
    REG_TRAILER2 = 2'd2,
    REG_MAX_LEN  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] trailer_first_byte;
    logic [BYTE_W-1:0] trailer_second_byte;
    logic [LEN_W-1:0]  max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic              frame_valid;
    logic [BYTE_W-1:0] payload_first;
    logic [BYTE_W-1:0] payload_second;
    logic [BYTE_W-1:0] payload_third;
  } frame_t;

endpackage

@@ src/htfr_byte_if.sv @@
// Received byte channel: valid/ready handshake with one byte per beat.
interface htfr_byte_if import htfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/htfr_frame_if.sv @@
// Frame result channel: valid/ready handshake with one result per beat.
interface htfr_frame_if import htfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic [BYTE_W-1:0] payload_first;
  logic [BYTE_W-1:0] payload_second;
  logic [BYTE_W-1:0] payload_third;

  modport source (output valid, output frame_valid, output payload_first,
                  output payload_second, output payload_third, input ready);
  modport sink (input valid, input frame_valid, input payload_first,
                input payload_second, input payload_third, output ready);
endinterface

@@ src/header_trailer_frame_receiver_top.sv @@
// Header/trailer frame receiver: byte deframer with APB register port.
//
// byte_i carries one received byte per beat. Every accepted byte yields
// exactly one beat on frame_o; frame_valid is set on the beat of the byte
// that closed a frame (second trailer byte right after the first trailer
// byte), and the first three stored bytes are shown then, zero otherwise.
// Frame start, trailer bytes and the length limit come from four APB
// registers at byte addresses 0, 4, 8 and 12; write them only while idle.
// The result of an accepted byte is registered in the result register, or
// in the skid register while frame_o stalls. Throughput is one byte per
// cycle while byte_i ready is high, set by the compare-and-store frame update.
// A two-entry output stage (result register plus skid register) decouples
// the sides: with frame_o stalled one more byte is taken, then byte_i
// ready drops until frame_o drains.
// Reset loads the register defaults, leaves the receiver waiting for a
// header, empties the output stage and zeroes the frame buffer.
module header_trailer_frame_receiver_top import htfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  htfr_byte_if.sink         byte_i,
  htfr_frame_if.source      frame_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  cfg_t              cfg_q;
  reg_idx_e          reg_idx;
  logic              cfg_we;

  logic              in_frame_q, in_frame_d;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic [BYTE_W-1:0] frame_buf_q [BUF_DEPTH];

  logic              fire_in, fire_out;
  logic              store;
  logic              match;
  logic [IDX_W-1:0]  prev_idx;
  logic [CMP_W-1:0]  fill_n;
  logic [CMP_W-1:0]  lim;
  frame_t            res_d;

  logic              out_valid_q, skid_valid_q;
  frame_t            out_q, skid_q;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HEADER:   prdata = APB_W'(cfg_q.header_byte);
      REG_TRAILER1: prdata = APB_W'(cfg_q.trailer_first_byte);
      REG_TRAILER2: prdata = APB_W'(cfg_q.trailer_second_byte);
      REG_MAX_LEN:  prdata = APB_W'(cfg_q.max_frame_length);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte         <= HEADER_RST;
      cfg_q.trailer_first_byte  <= TRAILER1_RST;
      cfg_q.trailer_second_byte <= TRAILER2_RST;
      cfg_q.max_frame_length    <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_HEADER:   cfg_q.header_byte         <= pwdata[BYTE_W-1:0];
        REG_TRAILER1: cfg_q.trailer_first_byte  <= pwdata[BYTE_W-1:0];
        REG_TRAILER2: cfg_q.trailer_second_byte <= pwdata[BYTE_W-1:0];
        REG_MAX_LEN:  cfg_q.max_frame_length    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign byte_i.ready = !skid_valid_q;
  assign fire_in      = byte_i.valid && byte_i.ready;
  assign fire_out     = out_valid_q && frame_o.ready;

  // Frame state update
  assign lim = (CMP_W'(cfg_q.max_frame_length) > CMP_W'(BUF_DEPTH))
             ? CMP_W'(BUF_DEPTH) : CMP_W'(cfg_q.max_frame_length);
  assign prev_idx = fill_q - IDX_W'(1);

  always_comb begin
    in_frame_d = in_frame_q;
    fill_n     = CMP_W'(fill_q);
    store      = 1'b0;
    match      = 1'b0;
    if (!in_frame_q) begin
      if (byte_i.rx_byte == cfg_q.header_byte) begin
        in_frame_d = 1'b1;
      end
      fill_n = '0;
    end else if (byte_i.rx_byte == cfg_q.trailer_second_byte) begin
      match = (fill_q != '0) && (frame_buf_q[prev_idx] == cfg_q.trailer_first_byte);
      if (match) begin
        in_frame_d = 1'b0;
        fill_n     = '0;
      end else begin
        store = 1'b1;
      end
    end else begin
      store = 1'b1;
    end
    if (store) begin
      fill_n = CMP_W'(fill_q) + CMP_W'(1);
    end
    if (fill_n >= lim) begin
      fill_n     = '0;
      in_frame_d = 1'b0;
    end
    fill_d = fill_n[IDX_W-1:0];
  end

  always_comb begin
    res_d.frame_valid    = match;
    res_d.payload_first  = match ? frame_buf_q[0] : '0;
    res_d.payload_second = match ? frame_buf_q[1] : '0;
    res_d.payload_third  = match ? frame_buf_q[2] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      fill_q     <= '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        frame_buf_q[i] <= '0;
      end
    end else if (fire_in) begin
      in_frame_q <= in_frame_d;
      fill_q     <= fill_d;
      if (store) begin
        frame_buf_q[fill_q] <= byte_i.rx_byte;
      end
    end
  end

  // Output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (fire_out || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= fire_in;
      end
    end else if (fire_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (fire_in) begin
        out_q <= res_d;
      end
    end else if (fire_in) begin
      skid_q <= res_d;
    end
  end

  assign frame_o.valid          = out_valid_q;
  assign frame_o.frame_valid    = out_q.frame_valid;
  assign frame_o.payload_first  = out_q.payload_first;
  assign frame_o.payload_second = out_q.payload_second;
  assign frame_o.payload_third  = out_q.payload_third;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (fill_q == '0))
    else $error("fill count nonzero while waiting for header");

  a_frame_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_in && res_d.frame_valid) |=> (!in_frame_q && (fill_q == '0)))
    else $error("receiver still collecting after a completed frame");

  a_no_match_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> !res_d.frame_valid)
    else $error("frame reported while waiting for header");

endmodule
